// ===== hdl/merge_sorter_core_defines.svh =====
// Assertion shorthands, clocked on clk and disabled while rst_n is low.
`ifndef MERGE_SORTER_CORE_DEFINES_SVH
`define MERGE_SORTER_CORE_DEFINES_SVH

// same-cycle implication
`define MSORT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSORT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/msort_pkg.sv =====
`default_nettype none

package msort_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [VALUE_WIDTH-1:0] word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last_item;
    } item_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_out;
        logic               overflow;
    } result_t;

    typedef struct packed {
        logic  wr_en0;
        logic  wr_en1;
        addr_t wr_addr;
        word_t wr_data;
        addr_t rd_addr_a;
        addr_t rd_addr_b;
        logic  rd_sel;
    } mem_ctl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_GROUP,
        ST_MERGE,
        ST_EMIT_REQ,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/msort_ram.sv =====
`default_nettype none

module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr_b,
    output logic      [WIDTH-1:0]                 rd_data_a,
    output logic      [WIDTH-1:0]                 rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_reg[rd_addr_a];
        rd_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== hdl/msort_seq.sv =====
`default_nettype none

module msort_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire msort_pkg::item_t    item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output msort_pkg::result_t       result,
    output msort_pkg::mem_ctl_t      mem_ctl,
    input  wire msort_pkg::word_t    rd_data_a,
    input  wire msort_pkg::word_t    rd_data_b
);

    localparam int CW = msort_pkg::CNT_W;
    localparam int AW = msort_pkg::ADDR_W;

    msort_pkg::state_t  state_reg, state_next;
    msort_pkg::cnt_t    count_reg, count_next;
    msort_pkg::cnt_t    width_reg, width_next;
    msort_pkg::cnt_t    lo_reg, lo_next;
    msort_pkg::cnt_t    mid_reg, mid_next;
    msort_pkg::cnt_t    hi_reg, hi_next;
    msort_pkg::cnt_t    i_reg, i_next;
    msort_pkg::cnt_t    j_reg, j_next;
    msort_pkg::cnt_t    k_reg, k_next;
    logic               ovf_reg, ovf_next;
    logic               src_reg, src_next;
    logic               out_valid_reg, out_valid_next;
    msort_pkg::result_t out_reg, out_next;

    logic            accept;
    logic            room;
    msort_pkg::cnt_t count_inc;
    logic [CW+1:0]   lo_plus_w;
    logic [CW+1:0]   lo_plus_2w;
    msort_pkg::cnt_t mid_c;
    msort_pkg::cnt_t hi_c;
    logic            a_ok;
    logic            b_ok;
    logic            take_a;
    msort_pkg::cnt_t k_inc;
    logic            group_end;
    logic            pass_end;
    logic [CW:0]     width_dbl;
    logic            sort_done;
    logic            fire;
    logic            emit_last;

    assign accept     = item_valid && (state_reg == msort_pkg::ST_LOAD);
    assign room       = count_reg < CW'(msort_pkg::MAX_ITEMS);
    assign count_inc  = room ? count_reg + 1'b1 : count_reg;
    assign lo_plus_w  = {2'b00, lo_reg} + {2'b00, width_reg};
    assign lo_plus_2w = {2'b00, lo_reg} + {1'b0, width_reg, 1'b0};
    assign mid_c      = (lo_plus_w > {2'b00, count_reg}) ? count_reg : lo_plus_w[CW-1:0];
    assign hi_c       = (lo_plus_2w > {2'b00, count_reg}) ? count_reg : lo_plus_2w[CW-1:0];
    assign a_ok       = i_reg < mid_reg;
    assign b_ok       = j_reg < hi_reg;
    assign take_a     = a_ok && (!b_ok || ($signed(rd_data_a) <= $signed(rd_data_b)));
    assign k_inc      = k_reg + 1'b1;
    assign group_end  = k_inc == hi_reg;
    assign pass_end   = hi_reg == count_reg;
    assign width_dbl  = {width_reg, 1'b0};
    assign sort_done  = width_dbl >= {1'b0, count_reg};
    assign fire       = !out_valid_reg || result_ready;
    assign emit_last  = k_inc == count_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msort_pkg::ST_LOAD:
            begin
                if (accept && item.last_item)
                begin
                    state_next = (count_inc <= CW'(1)) ? msort_pkg::ST_EMIT_REQ
                                                       : msort_pkg::ST_GROUP;
                end
            end
            msort_pkg::ST_GROUP:
            begin
                state_next = msort_pkg::ST_MERGE;
            end
            msort_pkg::ST_MERGE:
            begin
                if (group_end)
                begin
                    state_next = (pass_end && sort_done) ? msort_pkg::ST_EMIT_REQ
                                                         : msort_pkg::ST_GROUP;
                end
            end
            msort_pkg::ST_EMIT_REQ:
            begin
                state_next = msort_pkg::ST_EMIT;
            end
            msort_pkg::ST_EMIT:
            begin
                if (fire && emit_last)
                begin
                    state_next = msort_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = msort_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        ovf_next       = ovf_reg;
        src_next       = src_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;

        mem_ctl           = '0;
        mem_ctl.rd_sel    = src_reg;
        mem_ctl.wr_addr   = k_reg[AW-1:0];
        mem_ctl.rd_addr_a = i_reg[AW-1:0];
        mem_ctl.rd_addr_b = j_reg[AW-1:0];

        case (state_reg)
            msort_pkg::ST_LOAD:
            begin
                mem_ctl.wr_addr = count_reg[AW-1:0];
                mem_ctl.wr_data = msort_pkg::VALUE_WIDTH'(item.value);
                if (accept)
                begin
                    if (room)
                    begin
                        mem_ctl.wr_en0 = 1'b1;
                        count_next     = count_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last_item)
                    begin
                        width_next = CW'(1);
                        lo_next    = '0;
                        k_next     = '0;
                        src_next   = 1'b0;
                    end
                end
            end
            msort_pkg::ST_GROUP:
            begin
                i_next            = lo_reg;
                j_next            = mid_c;
                k_next            = lo_reg;
                mid_next          = mid_c;
                hi_next           = hi_c;
                mem_ctl.rd_addr_a = lo_reg[AW-1:0];
                mem_ctl.rd_addr_b = mid_c[AW-1:0];
            end
            msort_pkg::ST_MERGE:
            begin
                mem_ctl.wr_en0  = src_reg;
                mem_ctl.wr_en1  = !src_reg;
                mem_ctl.wr_data = take_a ? rd_data_a : rd_data_b;
                if (take_a)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
                mem_ctl.rd_addr_a = i_next[AW-1:0];
                mem_ctl.rd_addr_b = j_next[AW-1:0];
                k_next            = k_inc;
                if (group_end)
                begin
                    if (pass_end)
                    begin
                        src_next   = !src_reg;
                        width_next = width_dbl[CW-1:0];
                        lo_next    = '0;
                        k_next     = '0;
                    end
                    else
                    begin
                        lo_next = hi_reg;
                    end
                end
            end
            msort_pkg::ST_EMIT_REQ:
            begin
                mem_ctl.rd_addr_a = k_reg[AW-1:0];
            end
            msort_pkg::ST_EMIT:
            begin
                mem_ctl.rd_addr_a = fire ? k_inc[AW-1:0] : k_reg[AW-1:0];
                if (fire)
                begin
                    out_valid_next        = 1'b1;
                    out_next.sorted_value = 32'(rd_data_a);
                    out_next.last_out     = emit_last;
                    out_next.overflow     = ovf_reg;
                    k_next                = k_inc;
                    if (emit_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msort_pkg::ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        out_reg   <= out_next;
    end

    assign item_ready   = state_reg == msort_pkg::ST_LOAD;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ===== hdl/merge_sorter_core.sv =====
// channel   dir   handshake                    beat
// item      in    item_valid / item_ready      msort_pkg::item_t   (value, last_item)
// result    out   result_valid / result_ready  msort_pkg::result_t (sorted_value, last_out,
//                                                                   overflow)
//
// Load: one beat per cycle into buffer 0; items arriving while full are dropped.
// Sort: ceil(log2 n) bottom-up passes ping-ponging between two RAMs; each pass
//   takes a setup state (ST_GROUP) per merged group and one merge write per item.
// Emit: a setup state (ST_EMIT_REQ), then one result per cycle while result_ready is high.
// Sorting speed is set by the single merge write per cycle.
// item_ready is low from the last beat until the final result is registered.
// Buffers are not cleared at reset; only state, count, overflow, src and valid registers are.
`default_nettype none

`include "merge_sorter_core_defines.svh"

module merge_sorter_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire msort_pkg::item_t    item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output msort_pkg::result_t       result
);

    msort_pkg::mem_ctl_t mem_ctl;
    msort_pkg::word_t    m0_rd_a;
    msort_pkg::word_t    m0_rd_b;
    msort_pkg::word_t    m1_rd_a;
    msort_pkg::word_t    m1_rd_b;
    msort_pkg::word_t    rd_data_a;
    msort_pkg::word_t    rd_data_b;

    msort_ram #(
        .WIDTH (msort_pkg::VALUE_WIDTH),
        .DEPTH (msort_pkg::MAX_ITEMS)
    ) u_buf0 (
        .clk       (clk),
        .wr_en     (mem_ctl.wr_en0),
        .wr_addr   (mem_ctl.wr_addr),
        .wr_data   (mem_ctl.wr_data),
        .rd_addr_a (mem_ctl.rd_addr_a),
        .rd_addr_b (mem_ctl.rd_addr_b),
        .rd_data_a (m0_rd_a),
        .rd_data_b (m0_rd_b)
    );

    msort_ram #(
        .WIDTH (msort_pkg::VALUE_WIDTH),
        .DEPTH (msort_pkg::MAX_ITEMS)
    ) u_buf1 (
        .clk       (clk),
        .wr_en     (mem_ctl.wr_en1),
        .wr_addr   (mem_ctl.wr_addr),
        .wr_data   (mem_ctl.wr_data),
        .rd_addr_a (mem_ctl.rd_addr_a),
        .rd_addr_b (mem_ctl.rd_addr_b),
        .rd_data_a (m1_rd_a),
        .rd_data_b (m1_rd_b)
    );

    assign rd_data_a = mem_ctl.rd_sel ? m1_rd_a : m0_rd_a;
    assign rd_data_b = mem_ctl.rd_sel ? m1_rd_b : m0_rd_b;

    msort_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mem_ctl      (mem_ctl),
        .rd_data_a    (rd_data_a),
        .rd_data_b    (rd_data_b)
    );

    `MSORT_ASSERT_IMP(a_no_merge_write_in_load, item_ready, !mem_ctl.wr_en1, "merge write while loading")
    `MSORT_ASSERT_IMP(a_one_buffer_written, 1'b1, !(mem_ctl.wr_en0 && mem_ctl.wr_en1), "both buffers written")
    `MSORT_ASSERT_NXT(a_busy_after_last, item_valid && item_ready && item.last_item, !item_ready, "input open after last beat")

endmodule

`default_nettype wire
